FILE: hw/rtl/rpcr_pkg.sv
// ----------------------------------------------------------------------------
// rpcr_pkg: shared types and constants for the platform collision resolver
// Table geometry, coordinate widths, item modes, side codes, controller states
// and the command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpcr_pkg;

    localparam int MAX_PLATFORMS = 32;
    localparam int JUMP_MARGIN   = 10;

    localparam int ADDR_W  = (MAX_PLATFORMS > 1) ? $clog2(MAX_PLATFORMS) : 1;
    localparam int CNT_W   = $clog2(MAX_PLATFORMS + 1);

    localparam int POS_W   = 16;
    localparam int DIM_W   = 15;
    localparam int IDX_W   = 5;
    localparam int COUNT_W = 6;
    localparam int OUT_W   = 17;
    // working width for sums: wide enough that no sum or difference overflows
    localparam int CW      = 18;
    localparam int ENTRY_W = 2 * POS_W + 2 * DIM_W;

    localparam logic signed [CW-1:0] MARGIN_S = CW'(JUMP_MARGIN);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } t_side;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_entry;

    typedef struct packed {
        logic              load;
        logic              capture;
        logic              push;
        logic              wr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/rect_platform_collision_resolve_top.sv
// ----------------------------------------------------------------------------
// rect_platform_collision_resolve_top: platform collision resolver
// A write item goes straight into the table. A query scans one table entry per
// cycle, up to the scan count capped at 32, and stops early on a hit; the next
// item is taken once its result has moved into the output register.
// A result waits in the output register while the next item is accepted.
// Synchronous active-low reset clears the control state and the scan count;
// the platform table is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module rect_platform_collision_resolve_top import rpcr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [COUNT_W-1:0]      i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_mode,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [POS_W-1:0] i_rect_x,
    input  logic signed [POS_W-1:0] i_rect_y,
    input  logic [DIM_W-1:0]        i_rect_w,
    input  logic [DIM_W-1:0]        i_rect_h,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_hit_side,
    output logic signed [OUT_W-1:0] o_new_x,
    output logic signed [OUT_W-1:0] o_new_y
);

    t_cmd   cmd;
    t_sts   sts;
    t_entry wr_entry;
    t_entry rd_entry;

    assign wr_entry.x = i_rect_x;
    assign wr_entry.y = i_rect_y;
    assign wr_entry.w = i_rect_w;
    assign wr_entry.h = i_rect_h;

    rpcr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PLATFORMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (cmd.wr),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata (wr_entry),
        .i_re    (cmd.rd_en),
        .i_raddr (cmd.rd_addr),
        .o_rdata (rd_entry)
    );

    rpcr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    rpcr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .i_rdata     (rd_entry),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit_side  (o_hit_side),
        .o_new_x     (o_new_x),
        .o_new_y     (o_new_y)
    );

endmodule

FILE: hw/rtl/rpcr_ram.sv
// ----------------------------------------------------------------------------
// rpcr_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rpcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rpcr_ctrl.sv
// ----------------------------------------------------------------------------
// rpcr_ctrl: scan controller
// Holds the scan count register, accepts items, sequences the table
// reads of a query and hands the result to the output register.
// ----------------------------------------------------------------------------
module rpcr_ctrl import rpcr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  t_sts               i_sts,
    output t_cmd               o_cmd
);

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_scan_count;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_pend, n_pend;
    logic               accept;
    logic [CNT_W-1:0]   sat_count;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign sat_count  = (32'(r_scan_count) > MAX_PLATFORMS) ?
                        CNT_W'(MAX_PLATFORMS) : CNT_W'(r_scan_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan_count <= '0;
            r_cnt        <= '0;
            r_n          <= '0;
            r_pend       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_scan_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_n           = r_n;
        n_pend        = 1'b0;
        o_cmd         = '0;
        o_cmd.rd_addr = r_cnt[ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = '0;
                        n_n        = sat_count;
                        n_state    = ST_SCAN;
                    end else begin
                        // drop writes to slots beyond the table
                        o_cmd.wr = (32'(i_entry_index) < MAX_PLATFORMS);
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.capture = r_pend && i_sts.hit;
                if ((r_pend && i_sts.hit) || (r_cnt == r_n)) begin
                    n_state = ST_DONE;
                end else begin
                    // one read in flight; its data is checked next cycle
                    o_cmd.rd_en = 1'b1;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_pend      = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/rpcr_dp.sv
// ----------------------------------------------------------------------------
// rpcr_dp: collision datapath
// Holds the query rectangle, tests one table entry per cycle for a top,
// bottom, right or left hit, keeps the result and drives the output register.
// ----------------------------------------------------------------------------
module rpcr_dp import rpcr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic signed [POS_W-1:0] i_rect_x,
    input  logic signed [POS_W-1:0] i_rect_y,
    input  logic [DIM_W-1:0]        i_rect_w,
    input  logic [DIM_W-1:0]        i_rect_h,
    input  t_entry                  i_rdata,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_hit_side,
    output logic signed [OUT_W-1:0] o_new_x,
    output logic signed [OUT_W-1:0] o_new_y
);

    logic signed [POS_W-1:0] r_px, r_py;
    logic [DIM_W-1:0]        r_pw, r_ph;
    t_side                   r_side;
    logic signed [CW-1:0]    r_nx, r_ny;
    logic                    r_out_vld;
    t_side                   r_out_side;
    logic signed [OUT_W-1:0] r_out_x, r_out_y;

    logic signed [CW-1:0] px, py, pw, ph, lx, ly, lw, lh;
    logic signed [CW-1:0] px_r, py_b, lx_r, ly_b;
    logic                 top_y, bot_y, x_in_r, x_in_l, vo;
    logic                 hit_top, hit_bot, hit_right, hit_left;
    t_side                side;
    logic signed [CW-1:0] cand_x, cand_y;

    assign px   = CW'(r_px);
    assign py   = CW'(r_py);
    assign pw   = CW'(r_pw);
    assign ph   = CW'(r_ph);
    assign lx   = CW'($signed(i_rdata.x));
    assign ly   = CW'($signed(i_rdata.y));
    assign lw   = CW'(i_rdata.w);
    assign lh   = CW'(i_rdata.h);
    assign px_r = px + pw;
    assign py_b = py + ph;
    assign lx_r = lx + lw;
    assign ly_b = ly + lh;

    assign top_y  = (ly < py_b) && (py_b < ly_b);
    assign bot_y  = (ly < py) && (py < ly_b);
    assign x_in_l = (lx < px) && (px < lx_r);
    assign x_in_r = (lx < px_r) && (px_r < lx_r);
    assign vo     = bot_y || top_y || ((py < ly) && (py_b > ly_b));

    // the margin keeps a rectangle that only clips a corner from landing
    assign hit_top   = top_y && (((px_r - MARGIN_S > lx) && (px_r < lx_r)) ||
                                 ((px > lx) && (px + MARGIN_S < lx_r)));
    assign hit_bot   = bot_y && (x_in_r || x_in_l);
    assign hit_right = x_in_l && vo;
    assign hit_left  = x_in_r && vo;

    always_comb begin
        side   = SIDE_NONE;
        cand_x = px;
        cand_y = py;
        if (hit_top) begin
            side   = SIDE_TOP;
            cand_y = ly - ph;
        end else if (hit_bot) begin
            side   = SIDE_BOTTOM;
            cand_y = ly_b;
        end else if (hit_right) begin
            side   = SIDE_RIGHT;
            cand_x = lx_r;
        end else if (hit_left) begin
            side   = SIDE_LEFT;
            cand_x = lx - pw;
        end
    end

    assign o_sts.hit      = (side != SIDE_NONE);
    assign o_sts.out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_rect_x;
            r_py   <= i_rect_y;
            r_pw   <= i_rect_w;
            r_ph   <= i_rect_h;
            r_side <= SIDE_NONE;
            r_nx   <= CW'(i_rect_x);
            r_ny   <= CW'(i_rect_y);
        end else if (i_cmd.capture) begin
            r_side <= side;
            r_nx   <= cand_x;
            r_ny   <= cand_y;
        end
        if (i_cmd.push) begin
            r_out_side <= r_side;
            r_out_x    <= r_nx[OUT_W-1:0];
            r_out_y    <= r_ny[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_hit_side  = r_out_side;
    assign o_new_x     = r_out_x;
    assign o_new_y     = r_out_y;

endmodule

FILE: hw/rtl/rpcr_chk.sv
// ----------------------------------------------------------------------------
// rpcr_chk: port-level checks for the platform collision resolver
// Watches the top level's ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module rpcr_chk import rpcr_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    i_mode,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [2:0]              o_hit_side,
    input logic signed [OUT_W-1:0] o_new_x,
    input logic signed [OUT_W-1:0] o_new_y
);

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_hit_side) && $stable(o_new_x) && $stable(o_new_y))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_side_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit_side <= SIDE_BOTTOM))
        else $error("side code out of range");

    // a table write transfer gives no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_mode == MODE_WRITE) && !o_out_valid
            |=> !o_out_valid)
        else $error("result after a table write");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_mode == MODE_QUERY) |=> o_in_stall)
        else $error("query accepted without holding the input");

endmodule

bind rect_platform_collision_resolve_top rpcr_chk u_rpcr_chk (.*);

FILE: dv/rect_platform_collision_resolve_top_test.sv
// ----------------------------------------------------------------------------
// rect_platform_collision_resolve_top_test: platform collision resolver bench
// Loads the platform table, sets the scan count and fires query rectangles.
// Every query is predicted on acceptance and each returned transfer is
// compared field by field with the oldest prediction. A directed table comes
// first, then random phases at several scan counts, under random sender
// bursts and receiver stalls.
// ----------------------------------------------------------------------------
module rect_platform_collision_resolve_top_test import rpcr_pkg::*;;

    localparam int   NUM_DIRECTED    = 20;
    localparam int   NUM_PHASES      = 12;
    localparam int   ITEMS_PER_PHASE = 112;
    localparam int   DRAIN_TAIL      = 40;
    localparam int   LONG_HOLD       = 400;
    localparam int   MAX_REPORTS     = 40;

    typedef struct packed {
        logic                    mode;
        logic [IDX_W-1:0]        idx;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DIM_W-1:0]        w;
        logic [DIM_W-1:0]        h;
    } t_rect_item;

    typedef struct packed {
        t_side            side;
        logic [OUT_W-1:0] nx;
        logic [OUT_W-1:0] ny;
    } t_resolve;

    typedef struct packed {
        int x;
        int y;
        int w;
        int h;
    } t_platform;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUERY,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [IDX_W-1:0]        idx;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DIM_W-1:0]        w;
        logic [DIM_W-1:0]        h;
        logic [COUNT_W-1:0]      cfg;
        logic                    pinned;
        t_resolve                want;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [COUNT_W-1:0]      i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_mode;
    logic [IDX_W-1:0]        i_entry_index;
    logic signed [POS_W-1:0] i_rect_x;
    logic signed [POS_W-1:0] i_rect_y;
    logic [DIM_W-1:0]        i_rect_w;
    logic [DIM_W-1:0]        i_rect_h;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [2:0]              o_hit_side;
    logic signed [OUT_W-1:0] o_new_x;
    logic signed [OUT_W-1:0] o_new_y;

    t_platform          plat_table [MAX_PLATFORMS];
    logic [COUNT_W-1:0] scan_count;
    t_resolve           pending_resolves [$];
    t_row               directed_rows [NUM_DIRECTED];
    int                 n_errors;
    bit                 hold_req;

    rect_platform_collision_resolve_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_w      (i_rect_w),
        .i_rect_h      (i_rect_h),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit_side    (o_hit_side),
        .o_new_x       (o_new_x),
        .o_new_y       (o_new_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] exp);
        if (n_errors < MAX_REPORTS) begin
            $display("mismatch: %s got %0d expected %0d", what, got, exp);
        end
        n_errors++;
    endtask

    function automatic bit strictly_between(int lo, int v, int hi);
        return lo < v && v < hi;
    endfunction

    // Scan entries in order; the first side test that fires wins.
    function automatic t_resolve resolve_query(int px, int py, int pw, int ph);
        t_resolve r;
        int       n;
        int       lx, ly, lw, lh;
        bit       vov;
        r.side = SIDE_NONE;
        r.nx   = OUT_W'(px);
        r.ny   = OUT_W'(py);
        n = (int'(scan_count) > MAX_PLATFORMS) ? MAX_PLATFORMS : int'(scan_count);
        for (int i = 0; i < n && r.side == SIDE_NONE; i++) begin
            lx  = plat_table[i].x;
            ly  = plat_table[i].y;
            lw  = plat_table[i].w;
            lh  = plat_table[i].h;
            vov = strictly_between(ly, py, ly + lh) ||
                  strictly_between(ly, py + ph, ly + lh) ||
                  (py < ly && py + ph > ly + lh);
            if (strictly_between(ly, py + ph, ly + lh) &&
                ((px + pw - JUMP_MARGIN > lx && px + pw < lx + lw) ||
                 (px > lx && px + JUMP_MARGIN < lx + lw))) begin
                r.side = SIDE_TOP;
                r.ny   = OUT_W'(ly - ph);
            end else if (strictly_between(ly, py, ly + lh) &&
                         (strictly_between(lx, px + pw, lx + lw) ||
                          strictly_between(lx, px, lx + lw))) begin
                r.side = SIDE_BOTTOM;
                r.ny   = OUT_W'(ly + lh);
            end else if (strictly_between(lx, px, lx + lw) && vov) begin
                r.side = SIDE_RIGHT;
                r.nx   = OUT_W'(lx + lw);
            end else if (strictly_between(lx, px + pw, lx + lw) && vov) begin
                r.side = SIDE_LEFT;
                r.nx   = OUT_W'(lx - pw);
            end
        end
        return r;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic t_rect_item random_platform(int slot);
        t_rect_item it;
        it.mode = MODE_WRITE;
        it.idx  = IDX_W'(slot);
        if ($urandom_range(0, 9) == 0) begin
            it.x = POS_W'($urandom);
            it.y = POS_W'($urandom);
            it.w = DIM_W'($urandom);
            it.h = DIM_W'($urandom);
        end else begin
            it.x = POS_W'(int'($urandom_range(0, 4000)) - 2000);
            it.y = POS_W'(int'($urandom_range(0, 4000)) - 2000);
            it.w = DIM_W'($urandom_range(0, 300));
            it.h = DIM_W'($urandom_range(0, 80));
        end
        return it;
    endfunction

    // Mostly rectangles placed around a scanned platform, so the side tests fire.
    function automatic t_rect_item random_item();
        t_rect_item it;
        int         n, e, pw, ph, roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            return random_platform($urandom_range(0, MAX_PLATFORMS - 1));
        end
        it.mode = MODE_QUERY;
        it.idx  = IDX_W'($urandom);
        if (roll < 76) begin
            n  = (int'(scan_count) > MAX_PLATFORMS) ? MAX_PLATFORMS : int'(scan_count);
            e  = (n == 0) ? $urandom_range(0, MAX_PLATFORMS - 1) : $urandom_range(0, n - 1);
            pw = $urandom_range(0, 150);
            ph = $urandom_range(0, 60);
            it.w = DIM_W'(pw);
            it.h = DIM_W'(ph);
            it.x = POS_W'(plat_table[e].x - pw - 20 +
                          int'($urandom_range(0, plat_table[e].w + pw + 40)));
            it.y = POS_W'(plat_table[e].y - ph - 20 +
                          int'($urandom_range(0, plat_table[e].h + ph + 40)));
        end else if (roll < 92) begin
            it.x = POS_W'($urandom);
            it.y = POS_W'($urandom);
            it.w = DIM_W'($urandom);
            it.h = DIM_W'($urandom);
        end else begin
            it.x = POS_W'(pick_extreme());
            it.y = POS_W'(pick_extreme());
            it.w = DIM_W'(pick_extreme());
            it.h = DIM_W'(pick_extreme());
        end
        return it;
    endfunction

    // Hold the item until a transfer, then update the table or predict a result.
    task automatic send_item(input t_rect_item it, input bit pinned, input t_resolve want);
        i_in_valid    <= 1'b1;
        i_mode        <= it.mode;
        i_entry_index <= it.idx;
        i_rect_x      <= it.x;
        i_rect_y      <= it.y;
        i_rect_w      <= it.w;
        i_rect_h      <= it.h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.mode == MODE_WRITE) begin
            plat_table[it.idx] = '{int'($signed(it.x)), int'($signed(it.y)),
                                   int'(it.w), int'(it.h)};
        end else if (pinned) begin
            pending_resolves.push_back(want);
        end else begin
            pending_resolves.push_back(resolve_query(int'($signed(it.x)),
                                                     int'($signed(it.y)),
                                                     int'(it.w), int'(it.h)));
        end
    endtask

    task automatic idle_for(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Writes leave no result behind, so allow a full scan after the last one.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_resolves.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_scan_count(input logic [COUNT_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scan_count = value;
    endtask

    always @(posedge i_clk) begin : check_results
        t_resolve want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_resolves.size() == 0) begin
                report_mismatch("result with nothing pending, side", o_hit_side, 0);
            end else begin
                want = pending_resolves.pop_front();
                if (o_hit_side !== want.side)
                    report_mismatch("hit_side", o_hit_side, want.side);
                if (o_new_x !== want.nx)
                    report_mismatch("new_x", o_new_x, $signed(want.nx));
                if (o_new_y !== want.ny)
                    report_mismatch("new_y", o_new_y, $signed(want.ny));
            end
        end
    end

    // Receiver: a random stall pattern, picked anew when its random run length ends.
    initial begin
        int left, pattern, tick;
        bit hold_done;
        left        = 0;
        pattern     = 0;
        tick        = 0;
        hold_done   = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (left == 0) begin
                pattern = $urandom_range(0, 3);
                left    = $urandom_range(20, 300);
            end
            left--;
            tick++;
            case (pattern)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 4) < 3);
                default: i_out_stall <= (tick % 3 == 0);
            endcase
        end
    end

    initial begin
        t_rect_item         it;
        int                 burst_left;
        bit                 bursty;
        logic [COUNT_W-1:0] setting;

        n_errors      = 0;
        hold_req      = 1'b0;
        scan_count    = '0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_mode        <= MODE_WRITE;
        i_entry_index <= '0;
        i_rect_x      <= '0;
        i_rect_y      <= '0;
        i_rect_w      <= '0;
        i_rect_h      <= '0;

        // kind, idx, x, y, w, h, cfg, pinned, expected result where pinned
        directed_rows = '{
            // nothing scanned after reset: side none, position unchanged
            '{ROW_QUERY, 0, -32768, -32768, 32767, 32767, 0, 1,
              '{SIDE_NONE, -32768, -32768}},
            '{ROW_QUERY, 31, 32767, 32767, 0, 0, 0, 1, '{SIDE_NONE, 32767, 32767}},
            '{ROW_WRITE, 0, 0, 0, 100, 20, 0, 0, '0},
            '{ROW_WRITE, 1, -32768, -32768, 32767, 32767, 0, 0, '0},
            '{ROW_WRITE, 31, 32767, 32767, 32767, 32767, 0, 0, '0},
            '{ROW_CFG, 0, 0, 0, 0, 0, 1, 0, '0},
            '{ROW_QUERY, 0, 10, -5, 30, 10, 0, 0, '0},     // top
            '{ROW_QUERY, 0, 80, -5, 40, 10, 0, 0, '0},     // top, left-edge clause
            '{ROW_QUERY, 0, 10, 15, 30, 10, 0, 0, '0},     // bottom
            '{ROW_QUERY, 0, 90, -5, 30, 40, 0, 0, '0},     // right, spanning
            '{ROW_QUERY, 0, -20, -5, 30, 40, 0, 0, '0},    // left, spanning
            '{ROW_QUERY, 0, -25, -5, 35, 10, 0, 0, '0},    // margin blocks top
            '{ROW_QUERY, 0, 10, -10, 30, 10, 0, 0, '0},    // touching edge
            '{ROW_QUERY, 0, 200, 0, 10, 10, 0, 0, '0},     // clear miss
            '{ROW_CFG, 0, 0, 0, 0, 0, 2, 0, '0},
            '{ROW_QUERY, 0, -100, -100, 10, 10, 0, 0, '0}, // new_y below 16 bits
            '{ROW_QUERY, 0, -32768, -32768, 32767, 32767, 0, 0, '0},
            '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, '0},
            '{ROW_CFG, 0, 0, 0, 0, 0, 0, 0, '0},
            '{ROW_QUERY, 0, 10, -5, 30, 10, 0, 1, '{SIDE_NONE, 10, -5}}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_scan_count(directed_rows[r].cfg);
            end else begin
                it.mode = (directed_rows[r].kind == ROW_QUERY) ? MODE_QUERY : MODE_WRITE;
                it.idx  = directed_rows[r].idx;
                it.x    = directed_rows[r].x;
                it.y    = directed_rows[r].y;
                it.w    = directed_rows[r].w;
                it.h    = directed_rows[r].h;
                send_item(it, directed_rows[r].pinned, directed_rows[r].want);
            end
        end

        // load every slot before any count that scans them
        for (int slot = 0; slot < MAX_PLATFORMS; slot++) begin
            if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 6));
            send_item(random_platform(slot), 1'b0, '0);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: setting = COUNT_W'(32);
                1: setting = COUNT_W'(63);
                2: setting = COUNT_W'(33);
                3: setting = COUNT_W'(1);
                4: setting = COUNT_W'(0);
                default: setting = COUNT_W'($urandom_range(1, 63));
            endcase
            write_scan_count(setting);
            bursty     = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // fill the block behind a long receiver hold-off
                if (phase == 1 && k == 10) hold_req = 1'b1;
                if (phase == 2 && k == 60) wait_drained();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if (bursty) idle_for($urandom_range(1, 12));
                end
                burst_left--;
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_drained();
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
